### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int SLOT_W = 3;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_ADD   = 1'b1;
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_DUE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic add_resp;
        logic tick_start;
        logic rd_en;
        logic take_due;
        logic emit_pend;
        logic emit_last;
        logic idx_inc;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic due;
        logic pend_vld;
        logic idx_end;
    } t_sts;

endpackage

### design/ptd_if.sv
`timescale 1ns / 1ps

interface ptd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] period;
    logic [31:0] now;

    modport source (output valid, output opcode, output period, output now, input ready);
    modport sink (input valid, input opcode, input period, input now, output ready);
endinterface

interface ptd_out_if import ptd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
    logic              last;

    modport source (output valid, output kind, output slot, output accepted, output last,
                    input ready);
    modport sink (input valid, input kind, input slot, input accepted, input last,
                  output ready);
endinterface

### design/ptd_dp.sv
`timescale 1ns / 1ps

module ptd_dp import ptd_pkg::*; #(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_period,
    input  logic [31:0] i_now,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    ptd_out_if.source   o_out
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [31:0]          r_per_mem [MAX_TASKS];
    logic [31:0]          r_lr_mem  [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_lr_vld;
    logic [31:0]          r_per_q;
    logic [31:0]          r_lr_q;
    logic                 r_lr_vld_q;
    logic [CW-1:0]        r_cnt;
    logic [IW-1:0]        r_idx;
    logic [31:0]          r_now;
    logic                 r_pend_vld;
    logic [IW-1:0]        r_pend_idx;
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_acc;
    logic                 r_out_last;

    logic                 w_full;
    logic [31:0]          w_lr_eff;
    logic [31:0]          w_elapsed;

    assign w_full    = (r_cnt == CW'(MAX_TASKS));
    // A slot that no tick has stamped yet counts as last run at time zero.
    assign w_lr_eff  = r_lr_vld_q ? r_lr_q : 32'd0;
    assign w_elapsed = r_now - w_lr_eff;

    assign o_sts.out_free = !r_out_valid || o_out.ready;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.due      = (w_elapsed >= r_per_q);
    assign o_sts.pend_vld = r_pend_vld;
    assign o_sts.idx_end  = ((CW'(r_idx) + CW'(1)) == r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_resp && !w_full) begin
            r_per_mem[r_cnt[IW-1:0]] <= i_period;
        end
        if (i_cmd.rd_en) begin
            r_per_q <= r_per_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_due) begin
            r_lr_mem[r_idx] <= r_now;
        end
        if (i_cmd.rd_en) begin
            r_lr_q     <= r_lr_mem[r_idx];
            r_lr_vld_q <= r_lr_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr_vld   <= '0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cmd.take_due) begin
                r_lr_vld[r_idx] <= 1'b1;
            end
            if (i_cmd.add_resp && !w_full) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.tick_start) begin
                r_idx      <= '0;
                r_pend_vld <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (i_cmd.take_due) begin
                    r_pend_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_now <= i_now;
        end
        if (i_cmd.take_due) begin
            r_pend_idx <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.add_resp || i_cmd.emit_pend) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_resp) begin
            r_out_kind <= KIND_ADD;
            r_out_slot <= w_full ? '0 : SLOT_W'(r_cnt);
            r_out_acc  <= !w_full;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_pend) begin
            r_out_kind <= KIND_DUE;
            r_out_slot <= SLOT_W'(r_pend_idx);
            r_out_acc  <= 1'b0;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.slot     = r_out_slot;
    assign o_out.accepted = r_out_acc;
    assign o_out.last     = r_out_last;

endmodule

### design/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl import ptd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_opcode,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_go;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    // A due slot must wait while the previous due slot cannot be handed to the output.
    assign w_go       = !(i_sts.due && i_sts.pend_vld && !i_sts.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_opcode == OP_TICK) && !i_sts.cnt_zero) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_go) begin
                    n_state = i_sts.idx_end ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.add_resp   = w_accept && (i_in_opcode == OP_ADD);
                o_cmd.tick_start = w_accept && (i_in_opcode == OP_TICK);
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_CHECK: begin
                o_cmd.take_due  = w_go && i_sts.due;
                o_cmd.emit_pend = w_go && i_sts.due && i_sts.pend_vld;
                o_cmd.idx_inc   = w_go && !i_sts.idx_end;
            end
            S_FLUSH: begin
                o_cmd.emit_pend = i_sts.pend_vld && i_sts.out_free;
                o_cmd.emit_last = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### design/periodic_task_dispatcher.sv
`timescale 1ns / 1ps
// Periodic task dispatcher: a table of up to MAX_TASKS periodic tasks. An add request
// (opcode 1) takes the next free slot and answers in the cycle after acceptance with one
// response carrying the slot and an accepted flag; a full table answers accepted = 0, slot 0.
// A tick request (opcode 0) carries the current time; every registered slot whose elapsed
// time (now - last run, modulo 2^32) is at least its period is reported in index order and
// restamped with now, the final report carrying last = 1; a tick with nothing due gives
// nothing. During a tick each slot is read in turn through the single registered read port
// of the period and last-run memories and then compared. Requests are taken one at a time,
// and a new request is taken only when the output register is empty or is being read in
// the same cycle.
`include "assert_macros.svh"

module periodic_task_dispatcher import ptd_pkg::*; #(
    parameter int MAX_TASKS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptd_in_if.sink    i_in,
    ptd_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    ptd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_sts       (w_sts),
        .o_in_ready  (i_in.ready),
        .o_cmd       (w_cmd)
    );

    ptd_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (i_in.period),
        .i_now    (i_in.now),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_out    (o_out)
    );

    `ASSERT_CLK(a_in_needs_free_out, i_clk, i_rst_n,
                (i_in.valid && i_in.ready) |-> (!o_out.valid || o_out.ready),
                "request taken while output register blocked")
    `ASSERT_CLK(a_emit_needs_free_out, i_clk, i_rst_n,
                w_cmd.emit_pend |-> w_sts.out_free,
                "due report loaded over a waiting result")
    `ASSERT_CLK(a_add_resp_last, i_clk, i_rst_n,
                (o_out.valid && (o_out.kind == KIND_ADD)) |-> o_out.last,
                "add response not marked last")
    `ASSERT_ALWAYS(a_cmd_exclusive, i_clk,
                   !(w_cmd.add_resp && w_cmd.emit_pend),
                   "add response and due report in the same cycle")

endmodule

### test/tb_periodic_task_dispatcher.sv
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher;
    import ptd_pkg::*;

    localparam int MAX_TASKS   = 8;
    localparam int RAND_ITEMS  = 350;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 2 * MAX_TASKS + 24;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
        logic              last;
    } t_dispatch_rec;

    // Tracks the task table and the reports each request should produce.
    class dispatch_scoreboard;
        logic [31:0]   period_tbl[MAX_TASKS];
        logic [31:0]   last_run_tbl[MAX_TASKS];
        int unsigned   task_cnt;
        t_dispatch_rec pending_q[$];
        int unsigned   mismatches;
        int unsigned   adds_seen;
        int unsigned   ticks_seen;
        int unsigned   reports_seen;
        int unsigned   due_seen;
        int unsigned   rejects_seen;

        function new();
            foreach (period_tbl[i]) begin
                period_tbl[i]   = '0;
                last_run_tbl[i] = '0;
            end
            task_cnt     = 0;
            mismatches   = 0;
            adds_seen    = 0;
            ticks_seen   = 0;
            reports_seen = 0;
            due_seen     = 0;
            rejects_seen = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_request(logic op, logic [31:0] period, logic [31:0] now);
            t_dispatch_rec rec;
            logic [31:0]   elapsed;
            int            queued;
            queued = pending_q.size();
            if (op == OP_ADD) begin
                adds_seen++;
                rec.kind = KIND_ADD;
                rec.last = 1'b1;
                if (task_cnt < MAX_TASKS) begin
                    period_tbl[task_cnt] = period;
                    rec.slot     = task_cnt[SLOT_W-1:0];
                    rec.accepted = 1'b1;
                    task_cnt++;
                end else begin
                    rec.slot     = '0;
                    rec.accepted = 1'b0;
                end
                pending_q.push_back(rec);
            end else begin
                ticks_seen++;
                for (int i = 0; i < task_cnt; i++) begin
                    elapsed = now - last_run_tbl[i];
                    if (elapsed >= period_tbl[i]) begin
                        last_run_tbl[i] = now;
                        rec.kind     = KIND_DUE;
                        rec.slot     = i[SLOT_W-1:0];
                        rec.accepted = 1'b0;
                        rec.last     = 1'b0;
                        pending_q.push_back(rec);
                    end
                end
                // Only the final report of a tick carries the last flag.
                if (pending_q.size() > queued) begin
                    rec = pending_q.pop_back();
                    rec.last = 1'b1;
                    pending_q.push_back(rec);
                end
            end
        endfunction

        function void check_result(t_dispatch_rec got);
            t_dispatch_rec exp;
            reports_seen++;
            if (got.kind == KIND_DUE) due_seen++;
            else if (!got.accepted) rejects_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected report: kind %0d slot %0d accepted %0d last %0d",
                       got.kind, got.slot, got.accepted, got.last);
                mismatches++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.kind !== exp.kind) begin
                $error("kind mismatch: expected %0d, got %0d", exp.kind, got.kind);
                mismatches++;
            end
            if (got.slot !== exp.slot) begin
                $error("slot mismatch: expected %0d, got %0d", exp.slot, got.slot);
                mismatches++;
            end
            if (got.accepted !== exp.accepted) begin
                $error("accepted mismatch: expected %0d, got %0d", exp.accepted, got.accepted);
                mismatches++;
            end
            if (got.last !== exp.last) begin
                $error("last mismatch: expected %0d, got %0d", exp.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ptd_in_if  in_bus ();
    ptd_out_if out_bus ();

    periodic_task_dispatcher #(
        .MAX_TASKS(MAX_TASKS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus.sink),
        .o_out  (out_bus.source)
    );

    dispatch_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int          hold_left     = 0;
    int unsigned cycle_cnt     = 0;
    logic [31:0] cur_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_dispatch_rec got;
        cycle_cnt++;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.kind     = out_bus.kind;
            got.slot     = out_bus.slot;
            got.accepted = out_bus.accepted;
            got.last     = out_bus.last;
            sb.check_result(got);
        end
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_cnt, sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Called and returns at a falling edge; valid stays high for a back-to-back request.
    task automatic send_request(input logic op, input logic [31:0] period,
                                input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid  <= 1'b1;
        in_bus.opcode <= op;
        in_bus.period <= period;
        in_bus.now    <= now;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_request(op, period, now);
        @(negedge i_clk);
    endtask

    task automatic add_task(input logic [31:0] period);
        send_request(OP_ADD, period, $urandom());
    endtask

    task automatic tick_at(input logic [31:0] now);
        send_request(OP_TICK, $urandom(), now);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic random_traffic(input int count);
        logic [31:0] period;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 8) begin
                pick = $urandom_range(0, 2);
                period = (pick == 0) ? $urandom_range(0, 20) :
                         (pick == 1) ? 32'hFFFF_FFFF : $urandom();
                add_task(period);
            end else begin
                pick = $urandom_range(0, 99);
                // Mostly a steadily advancing clock, with jumps and wrap-arounds.
                if (pick < 80)      cur_now += $urandom_range(0, 12);
                else if (pick < 90) cur_now += $urandom_range(0, 2000);
                else if (pick < 95) cur_now = $urandom();
                else                cur_now = 32'hFFFF_FFFF - $urandom_range(0, 8);
                tick_at(cur_now);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.opcode  = OP_TICK;
        in_bus.period  = '0;
        in_bus.now     = '0;
        out_bus.ready  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, zero and maximum periods, wrap of the clock,
        // filling the table and a rejected add.
        tick_at(32'd0);
        add_task(32'd0);
        tick_at(32'd0);
        add_task(32'hFFFF_FFFF);
        add_task(32'd5);
        tick_at(32'd3);
        tick_at(32'hFFFF_FFFF);
        tick_at(32'd2);
        add_task(32'd1);
        add_task(32'h8000_0000);
        add_task($urandom_range(2, 40));
        add_task($urandom_range(2, 40));
        add_task($urandom_range(2, 40));
        add_task($urandom());
        tick_at(32'h7FFF_FFFF);
        tick_at(32'h7FFF_FFFF);
        tick_at(32'h8000_0000);
        add_task(32'hFFFF_FFFF);
        tick_at(32'h8000_0000);
        cur_now = 32'h8000_0000;

        // No idling, but with a long stall at the output while requests keep coming.
        hold_requests++;
        random_traffic(RAND_ITEMS / 4);
        wait_drained();

        send_idle_pct = 66;
        stall_pct     = 0;
        random_traffic(RAND_ITEMS / 4);

        send_idle_pct = 0;
        stall_pct     = 66;
        random_traffic(RAND_ITEMS / 4);

        send_idle_pct = 11;
        stall_pct     = 11;
        random_traffic(RAND_ITEMS / 4);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Sent %0d adds and %0d ticks; checked %0d reports (%0d due, %0d rejected).",
                 sb.adds_seen, sb.ticks_seen, sb.reports_seen, sb.due_seen, sb.rejects_seen);
        $display("Idle phases covered no gaps, input gaps, output stalls and both.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
